FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every assertion samples on the rising edge of i_clk and is switched off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ON(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/atbp_pkg.sv
`timescale 1ns / 1ps

package atbp_pkg;

    // Fixed-point format: rates are Q16.FRAC_BITS, token levels Q32.FRAC_BITS.
    localparam int FRAC_BITS  = 16;
    localparam int RATE_W     = 32;
    localparam int TIME_W     = 32;
    localparam int COST_W     = 16;
    localparam int DEPTH_W    = 16;
    localparam int SCORE_W    = 16;
    localparam int LEVEL_W    = 32 + FRAC_BITS;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Request kinds.
    typedef logic [1:0] t_req_type;
    localparam t_req_type REQ_PACKET  = 2'd0;
    localparam t_req_type REQ_ADJUST  = 2'd1;
    localparam t_req_type REQ_AWARD   = 2'd2;
    localparam t_req_type REQ_RESTART = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RATE = 2'd1;

    // Register values after reset.
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd64;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 32'd65536;

    // floor(r / 5) for any 32-bit r equals (r * RECIP5) >> RECIP5_SHIFT.
    localparam logic [RATE_W-1:0] RECIP5       = 32'hCCCC_CCCD;
    localparam int                RECIP5_SHIFT = 34;
    localparam int                QUOT5_W      = RATE_W - 2;

    // Rate and score state, handed between the top level and the rate unit.
    typedef struct packed {
        logic [RATE_W-1:0]         rate_now;
        logic [RATE_W-1:0]         rate_before;
        logic signed [SCORE_W-1:0] score_up;
        logic signed [SCORE_W-1:0] score_down;
    } t_rate_state;

    // Full-bucket level for a given depth in whole tokens.
    function automatic logic [LEVEL_W-1:0] cap_of(input logic [DEPTH_W-1:0] depth);
        cap_of = {{(LEVEL_W - DEPTH_W - FRAC_BITS){1'b0}}, depth, {FRAC_BITS{1'b0}}};
    endfunction

endpackage

FILE: hw/rtl/atbp_channels.sv
`timescale 1ns / 1ps

// Request channel: one packet or control item per transfer.
interface atbp_req_if import atbp_pkg::*; ();
    logic              valid;
    logic              ready;
    t_req_type         req_type;
    logic [TIME_W-1:0] time_now;
    logic [COST_W-1:0] token_cost;
    logic [RATE_W-1:0] new_rate;

    modport source (output valid, output req_type, output time_now, output token_cost,
                    output new_rate, input ready);
    modport sink   (input valid, input req_type, input time_now, input token_cost,
                    input new_rate, output ready);
endinterface

// Result channel: one verdict and status word per transfer.
interface atbp_res_if import atbp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      dropped;
    logic [RATE_W-1:0]         current_rate;
    logic signed [SCORE_W-1:0] up_score;
    logic signed [SCORE_W-1:0] down_score;

    modport source (output valid, output dropped, output current_rate, output up_score,
                    output down_score, input ready);
    modport sink   (input valid, input dropped, input current_rate, input up_score,
                    input down_score, output ready);
endinterface

FILE: hw/rtl/atbp_refill.sv
`timescale 1ns / 1ps

// Bucket refill and policing decision for one packet.
module atbp_refill import atbp_pkg::*; (
    input  logic [LEVEL_W-1:0] i_level,
    input  logic [TIME_W-1:0]  i_last_time,
    input  logic [RATE_W-1:0]  i_rate,
    input  logic [DEPTH_W-1:0] i_depth,
    input  logic [TIME_W-1:0]  i_time_now,
    input  logic [COST_W-1:0]  i_token_cost,
    output logic [LEVEL_W-1:0] o_level,
    output logic               o_dropped
);

    localparam int ADD_W = TIME_W + RATE_W;

    logic [TIME_W-1:0]  ticks;
    logic [ADD_W-1:0]   add;
    logic [LEVEL_W-1:0] cap;
    logic [LEVEL_W-1:0] room;
    logic [LEVEL_W-1:0] need;
    logic [LEVEL_W-1:0] filled;
    logic               full;
    logic               pass;

    // Elapsed ticks wrap modulo the timer width; the product is exact.
    assign ticks = i_time_now - i_last_time;
    assign add   = {{RATE_W{1'b0}}, ticks} * {{TIME_W{1'b0}}, i_rate};

    // Refill, saturating at the bucket depth.
    assign cap    = cap_of(i_depth);
    assign room   = cap - i_level;
    assign full   = (i_level >= cap) || (add >= {{(ADD_W - LEVEL_W){1'b0}}, room});
    assign filled = full ? cap : (i_level + add[LEVEL_W-1:0]);

    // The packet passes and pays when enough tokens are held.
    assign need      = {{(LEVEL_W - COST_W - FRAC_BITS){1'b0}}, i_token_cost,
                        {FRAC_BITS{1'b0}}};
    assign pass      = (filled >= need);
    assign o_level   = pass ? (filled - need) : filled;
    assign o_dropped = !pass;

endmodule

FILE: hw/rtl/atbp_rate.sv
`timescale 1ns / 1ps

// Rate tuning: score bookkeeping and the plus or minus twenty percent rate step.
module atbp_rate import atbp_pkg::*; (
    input  t_req_type         i_req_type,
    input  logic [RATE_W-1:0] i_new_rate,
    input  t_rate_state       i_state,
    output t_rate_state       o_state
);

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_ONE = {{(SCORE_W-1){1'b0}}, 1'b1};

    logic [2*RATE_W-1:0]       prod5;
    logic [QUOT5_W-1:0]        quot5;
    logic [RATE_W-1:0]         five_q;
    logic                      rem5_nz;
    logic [RATE_W:0]           up_sum;
    logic [RATE_W-1:0]         rate_up;
    logic [RATE_W-1:0]         rate_down;
    logic [RATE_W-1:0]         cand;
    logic                      toward_down;
    logic signed [SCORE_W-1:0] up_dec;
    logic signed [SCORE_W-1:0] down_dec;
    logic signed [SCORE_W-1:0] up_inc;
    logic signed [SCORE_W-1:0] down_inc;

    // One step of a saturating score.
    function automatic logic signed [SCORE_W-1:0] sat_step(
        input logic signed [SCORE_W-1:0] s,
        input logic                      up
    );
        if (up) begin
            sat_step = (s == SCORE_MAX) ? s : s + SCORE_ONE;
        end else begin
            sat_step = (s == SCORE_MIN) ? s : s - SCORE_ONE;
        end
    endfunction

    // Divide the rate by five through the reciprocal; keep whether a remainder is left.
    assign prod5   = {{RATE_W{1'b0}}, i_state.rate_now} * {{RATE_W{1'b0}}, RECIP5};
    assign quot5   = prod5[RECIP5_SHIFT +: QUOT5_W];
    assign five_q  = {quot5, 2'b00} + {2'b00, quot5};
    assign rem5_nz = (five_q != i_state.rate_now);

    // floor(6r/5) = r + floor(r/5), saturated; floor(4r/5) = r - ceil(r/5).
    assign up_sum    = {1'b0, i_state.rate_now} + {3'b000, quot5};
    assign rate_up   = up_sum[RATE_W] ? {RATE_W{1'b1}} : up_sum[RATE_W-1:0];
    assign rate_down = i_state.rate_now - {2'b00, quot5} - {{(RATE_W-1){1'b0}}, rem5_nz};

    // The score that moves follows the direction of the last rate change.
    assign toward_down = (i_state.rate_before > i_state.rate_now);
    assign up_dec      = toward_down ? i_state.score_up : sat_step(i_state.score_up, 1'b0);
    assign down_dec    = toward_down ? sat_step(i_state.score_down, 1'b0) : i_state.score_down;
    assign up_inc      = toward_down ? i_state.score_up : sat_step(i_state.score_up, 1'b1);
    assign down_inc    = toward_down ? sat_step(i_state.score_down, 1'b1) : i_state.score_down;

    // An adjust raises the rate while the up score leads or ties.
    assign cand = ($signed(up_dec) >= $signed(down_dec)) ? rate_up : rate_down;

    // Next state per request kind; a rate is loaded only when it differs.
    always_comb begin
        o_state = i_state;
        unique case (i_req_type)
            REQ_PACKET: begin
                o_state = i_state;
            end
            REQ_ADJUST: begin
                o_state.score_up   = up_dec;
                o_state.score_down = down_dec;
                if (cand != i_state.rate_now) begin
                    o_state.rate_before = i_state.rate_now;
                    o_state.rate_now    = cand;
                end
            end
            REQ_AWARD: begin
                o_state.score_up   = up_inc;
                o_state.score_down = down_inc;
            end
            REQ_RESTART: begin
                o_state.score_up   = '0;
                o_state.score_down = '0;
                if (i_new_rate != i_state.rate_now) begin
                    o_state.rate_before = i_state.rate_now;
                    o_state.rate_now    = i_new_rate;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

FILE: hw/rtl/adaptive_token_bucket_policer_top.sv
`timescale 1ns / 1ps
// Adaptive token bucket policer.
// Requests arrive on i_req (valid/ready): a packet carries a timestamp and a token cost,
// control requests adjust the rate, award a score or restart with a new rate. Every
// request yields exactly one result on o_res: the drop verdict (packets only), the rate
// in force and both scores after the request.
// A request waits in the input register, from which the refill and rate logic load the result
// register as soon as that register is free; the result transfers to o_res from there.
// Throughput is one request per cycle while the receiver keeps up; the refill multiplier
// and the level compare feed the bucket state back combinationally.
// When the receiver stalls, the result register holds its item and one further request
// is still taken into the input register; only then does i_req.ready fall.
// Reset (synchronous, active low) fills the bucket to 64 tokens, loads a rate of
// 1.0 token per tick, clears the scores and the timestamp and empties both registers.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once; the user must
// make them while no request is in flight (not enforced); a depth write refills the bucket.
`include "assert_macros.svh"

module adaptive_token_bucket_policer_top import atbp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    atbp_req_if.sink              i_req,
    atbp_res_if.source            o_res
);

    // Input register.
    logic              r_in_valid;
    t_req_type         r_req_type;
    logic [TIME_W-1:0] r_time_now;
    logic [COST_W-1:0] r_token_cost;
    logic [RATE_W-1:0] r_new_rate;

    // Policer state.
    logic [DEPTH_W-1:0] r_depth;
    logic [LEVEL_W-1:0] r_level;
    logic [TIME_W-1:0]  r_last_time;
    t_rate_state        r_st;

    // Result register.
    logic                      r_out_valid;
    logic                      r_res_dropped;
    logic [RATE_W-1:0]         r_res_rate;
    logic signed [SCORE_W-1:0] r_res_up;
    logic signed [SCORE_W-1:0] r_res_down;

    logic               in_fire;
    logic               out_free;
    logic               advance;
    logic               is_packet;
    logic               ctrl_adv;
    logic               restart_adv;
    logic               scores_clear;
    logic [LEVEL_W-1:0] n_level;
    logic               n_dropped;
    t_rate_state        n_st;

    // Handshake: the result register frees the input register whenever it can take an item.
    assign out_free    = !r_out_valid || o_res.ready;
    assign advance     = r_in_valid && out_free;
    assign i_req.ready = !r_in_valid || out_free;
    assign in_fire     = i_req.valid && i_req.ready;
    assign is_packet   = (r_req_type == REQ_PACKET);

    atbp_refill u_refill (
        .i_level      (r_level),
        .i_last_time  (r_last_time),
        .i_rate       (r_st.rate_now),
        .i_depth      (r_depth),
        .i_time_now   (r_time_now),
        .i_token_cost (r_token_cost),
        .o_level      (n_level),
        .o_dropped    (n_dropped)
    );

    atbp_rate u_rate (
        .i_req_type (r_req_type),
        .i_new_rate (r_new_rate),
        .i_state    (r_st),
        .o_state    (n_st)
    );

    // Control and policer state, including configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_depth          <= DEPTH_RESET;
            r_level          <= cap_of(DEPTH_RESET);
            r_last_time      <= '0;
            r_st.rate_now    <= RATE_RESET;
            r_st.rate_before <= '0;
            r_st.score_up    <= '0;
            r_st.score_down  <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BUCKET_DEPTH: begin
                        r_depth <= i_cfg_data[DEPTH_W-1:0];
                        r_level <= cap_of(i_cfg_data[DEPTH_W-1:0]);
                    end
                    REG_INITIAL_RATE: begin
                        r_st.rate_now    <= i_cfg_data[RATE_W-1:0];
                        r_st.rate_before <= '0;
                    end
                    default: begin
                        r_depth <= r_depth;
                    end
                endcase
            end else if (advance) begin
                r_st <= n_st;
                if (is_packet) begin
                    r_level     <= n_level;
                    r_last_time <= r_time_now;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req_type   <= i_req.req_type;
            r_time_now   <= i_req.time_now;
            r_token_cost <= i_req.token_cost;
            r_new_rate   <= i_req.new_rate;
        end
        if (advance) begin
            r_res_dropped <= is_packet && n_dropped;
            r_res_rate    <= n_st.rate_now;
            r_res_up      <= n_st.score_up;
            r_res_down    <= n_st.score_down;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.dropped      = r_res_dropped;
    assign o_res.current_rate = r_res_rate;
    assign o_res.up_score     = r_res_up;
    assign o_res.down_score   = r_res_down;

    // Terms used by the checks below.
    assign ctrl_adv     = advance && !is_packet;
    assign restart_adv  = advance && (r_req_type == REQ_RESTART);
    assign scores_clear = (r_st.score_up == '0) && (r_st.score_down == '0);

    // Checks on the policer's own logic.
    `ASSERT_ON(a_level_capped, r_level <= cap_of(r_depth), "token level above bucket cap")
    `ASSERT_NEXT(a_result_loaded, advance, r_out_valid, "processed request left no result")
    `ASSERT_NEXT(a_ctrl_no_drop, ctrl_adv, !r_res_dropped, "control request dropped")
    `ASSERT_NEXT(a_ctrl_keeps_time, ctrl_adv && !i_cfg_we, $stable(r_last_time), "time moved")
    `ASSERT_NEXT(a_restart_clears, restart_adv, scores_clear, "restart left scores set")

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import atbp_pkg::*;

    // One request as offered on the request channel.
    typedef struct packed {
        t_req_type           kind;
        logic [TIME_W-1:0]   stamp;
        logic [COST_W-1:0]   cost;
        logic [RATE_W-1:0]   rate;
    } t_req_item;

    // One verdict as returned on the result channel.
    typedef struct packed {
        logic                      dropped;
        logic [RATE_W-1:0]         rate;
        logic signed [SCORE_W-1:0] up;
        logic signed [SCORE_W-1:0] down;
    } t_verdict;

    // A directed request with, where it is obvious, the verdict written out by hand.
    typedef struct packed {
        t_req_item req;
        logic      typed;
        t_verdict  want;
    } t_script_row;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 2'd3;

    localparam int QUIET_LIMIT = 1000;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 150;

    localparam logic [DEPTH_W-1:0] DEPTH_PICKS [5] = '{16'd0, 16'd1, 16'd65535, 16'd64, 16'd3};
    localparam logic [RATE_W-1:0]  RATE_PICKS  [5] =
        '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd65536, 32'd12000};

    // Directed opening sequence, run with the reset register values.
    localparam int SCRIPT_LEN = 26;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        // Zero cost, emptying the bucket exactly, then one token short.
        '{'{REQ_PACKET, 32'd0, 16'd0, 32'd0}, 1'b1, '{1'b0, 32'd65536, 16'h0000, 16'h0000}},
        '{'{REQ_PACKET, 32'd0, 16'd64, 32'd0}, 1'b1, '{1'b0, 32'd65536, 16'h0000, 16'h0000}},
        '{'{REQ_PACKET, 32'd0, 16'd1, 32'd0}, 1'b1, '{1'b1, 32'd65536, 16'h0000, 16'h0000}},
        '{'{REQ_PACKET, 32'd3, 16'd3, 32'd0}, 1'b1, '{1'b0, 32'd65536, 16'h0000, 16'h0000}},
        '{'{REQ_PACKET, 32'd3, 16'hFFFF, 32'd0}, 1'b1, '{1'b1, 32'd65536, 16'h0000, 16'h0000}},
        '{'{REQ_PACKET, 32'd4, 16'd0, 32'd0}, 1'b1, '{1'b0, 32'd65536, 16'h0000, 16'h0000}},
        // Long gap: the refill stops at the cap, so a cost above the depth drops.
        '{'{REQ_PACKET, 32'd1000, 16'd65, 32'd0}, 1'b1, '{1'b1, 32'd65536, 16'h0000, 16'h0000}},
        // Score and rate control, with noise on the fields that are ignored.
        '{'{REQ_AWARD, 32'hFFFF_FFFF, 16'hFFFF, 32'h1234_5678}, 1'b1,
          '{1'b0, 32'd65536, 16'h0001, 16'h0000}},
        '{'{REQ_ADJUST, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
          '{1'b0, 32'd78643, 16'h0000, 16'h0000}},
        '{'{REQ_AWARD, 32'h0, 16'h0, 32'h0}, 1'b1, '{1'b0, 32'd78643, 16'h0001, 16'h0000}},
        '{'{REQ_RESTART, 32'h5A5A_5A5A, 16'hA5A5, 32'hFFFF_FFFF}, 1'b1,
          '{1'b0, 32'hFFFF_FFFF, 16'h0000, 16'h0000}},
        '{'{REQ_ADJUST, 32'h0, 16'h0, 32'h0}, 1'b1, '{1'b0, 32'hCCCC_CCCC, 16'hFFFF, 16'h0000}},
        '{'{REQ_AWARD, 32'h0, 16'h0, 32'h0}, 1'b1, '{1'b0, 32'hCCCC_CCCC, 16'hFFFF, 16'h0001}},
        '{'{REQ_ADJUST, 32'h0, 16'h0, 32'h0}, 1'b0, '0},
        // Rate increase from the top value saturates and so leaves the rate alone.
        '{'{REQ_RESTART, 32'h0, 16'h0, 32'hFFFF_FFFF}, 1'b1,
          '{1'b0, 32'hFFFF_FFFF, 16'h0000, 16'h0000}},
        '{'{REQ_AWARD, 32'h0, 16'h0, 32'h0}, 1'b1, '{1'b0, 32'hFFFF_FFFF, 16'h0001, 16'h0000}},
        '{'{REQ_ADJUST, 32'h0, 16'h0, 32'h0}, 1'b1,
          '{1'b0, 32'hFFFF_FFFF, 16'h0000, 16'h0000}},
        '{'{REQ_PACKET, 32'h8000_0000, 16'd64, 32'h0}, 1'b1,
          '{1'b0, 32'hFFFF_FFFF, 16'h0000, 16'h0000}},
        // Zero rate, then a small rate that rounds back onto itself.
        '{'{REQ_RESTART, 32'h0, 16'h0, 32'd0}, 1'b1, '{1'b0, 32'd0, 16'h0000, 16'h0000}},
        '{'{REQ_ADJUST, 32'h0, 16'h0, 32'h0}, 1'b1, '{1'b0, 32'd0, 16'h0000, 16'hFFFF}},
        '{'{REQ_RESTART, 32'h0, 16'h0, 32'd4}, 1'b1, '{1'b0, 32'd4, 16'h0000, 16'h0000}},
        '{'{REQ_AWARD, 32'h0, 16'h0, 32'h0}, 1'b1, '{1'b0, 32'd4, 16'h0001, 16'h0000}},
        '{'{REQ_ADJUST, 32'h0, 16'h0, 32'h0}, 1'b1, '{1'b0, 32'd4, 16'h0000, 16'h0000}},
        // Restart with the rate already in force loads nothing.
        '{'{REQ_RESTART, 32'h0, 16'h0, 32'd4}, 1'b1, '{1'b0, 32'd4, 16'h0000, 16'h0000}},
        // Timestamp wrap: elapsed time is taken modulo the counter width.
        '{'{REQ_PACKET, 32'hFFFF_FFF0, 16'd1, 32'h0}, 1'b0, '0},
        '{'{REQ_PACKET, 32'h0000_0010, 16'd1, 32'h0}, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    atbp_req_if req_ch ();
    atbp_res_if res_ch ();

    adaptive_token_bucket_policer_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    always #5 clk = ~clk;

    // Policer state as the testbench predicts it.
    logic [DEPTH_W-1:0]        bkt_depth  = DEPTH_RESET;
    logic [63:0]               level      = 64'(DEPTH_RESET) << FRAC_BITS;
    logic [TIME_W-1:0]         last_stamp = '0;
    logic [RATE_W-1:0]         rate_cur   = RATE_RESET;
    logic [RATE_W-1:0]         rate_prev  = '0;
    logic signed [SCORE_W-1:0] sc_up      = '0;
    logic signed [SCORE_W-1:0] sc_down    = '0;

    t_verdict          verdict_q [$];
    logic [TIME_W-1:0] stamp_gen = '0;
    bit                send_calm  = 1'b0;
    bit                recv_calm  = 1'b0;
    int                bad_count     = 0;
    int                sent_count    = 0;
    int                checked_count = 0;
    int                drop_count    = 0;
    int                write_count   = 0;
    int                quiet_cycles  = 0;

    function automatic logic [63:0] bucket_cap();
        return 64'(bkt_depth) << FRAC_BITS;
    endfunction

    function automatic logic signed [SCORE_W-1:0] clamp_score(input int sum);
        if (sum > 32767) sum = 32767;
        if (sum < -32768) sum = -32768;
        return SCORE_W'(sum);
    endfunction

    // The score that moves follows the direction of the last rate change.
    function automatic void nudge_score(input int delta);
        if (rate_prev > rate_cur) begin
            sc_down = clamp_score(int'(sc_down) + delta);
        end else begin
            sc_up = clamp_score(int'(sc_up) + delta);
        end
    endfunction

    function automatic void load_rate(input logic [RATE_W-1:0] r);
        if (r != rate_cur) begin
            rate_prev = rate_cur;
            rate_cur  = r;
        end
    endfunction

    // Advance the predicted state by one request and return the verdict it yields.
    function automatic t_verdict police_step(input t_req_item r);
        t_verdict          v;
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       cap;
        logic [63:0]       gain;
        logic [63:0]       need;
        logic [63:0]       cand;
        v.dropped = 1'b0;
        case (r.kind)
            REQ_PACKET: begin
                cap     = bucket_cap();
                elapsed = r.stamp - last_stamp;
                gain    = 64'(elapsed) * 64'(rate_cur);
                need    = 64'(r.cost) << FRAC_BITS;
                if (level >= cap || gain >= cap - level) begin
                    level = cap;
                end else begin
                    level = level + gain;
                end
                last_stamp = r.stamp;
                if (level >= need) begin
                    level = level - need;
                end else begin
                    v.dropped = 1'b1;
                end
            end
            REQ_ADJUST: begin
                nudge_score(-1);
                if (sc_up >= sc_down) begin
                    cand = 64'(rate_cur) * 64'd6 / 64'd5;
                    if (cand > 64'hFFFF_FFFF) cand = 64'hFFFF_FFFF;
                end else begin
                    cand = 64'(rate_cur) * 64'd4 / 64'd5;
                end
                load_rate(cand[RATE_W-1:0]);
            end
            REQ_AWARD: begin
                nudge_score(1);
            end
            default: begin
                sc_up   = '0;
                sc_down = '0;
                load_rate(r.rate);
            end
        endcase
        v.rate = rate_cur;
        v.up   = sc_up;
        v.down = sc_down;
        return v;
    endfunction

    function automatic int draw_pause(input bit calm);
        if (calm) return 0;
        return $urandom_range(0, 19);
    endfunction

    // Random request: mostly packets on a rising clock, with fair control traffic.
    function automatic t_req_item make_item();
        t_req_item   r;
        int unsigned roll;
        int unsigned top_cost;
        r.stamp = $urandom;
        r.cost  = COST_W'($urandom);
        r.rate  = $urandom;
        roll    = $urandom_range(0, 99);
        if (roll < 60) begin
            r.kind = REQ_PACKET;
            roll   = $urandom_range(0, 99);
            if (roll < 70) begin
                stamp_gen += $urandom_range(0, 8);
            end else if (roll < 90) begin
                stamp_gen += $urandom_range(0, 200);
            end else if (roll < 97) begin
                stamp_gen += $urandom_range(0, 65535);
            end else begin
                stamp_gen += $urandom;
            end
            r.stamp = stamp_gen;
            // Most costs fall between zero and one above the depth so that both verdicts are common.
            if ($urandom_range(0, 3) != 0) begin
                top_cost = int'(bkt_depth) + 1;
                if (top_cost > 65535) top_cost = 65535;
                r.cost = COST_W'($urandom_range(0, top_cost));
            end
        end else if (roll < 75) begin
            r.kind = REQ_ADJUST;
        end else if (roll < 88) begin
            r.kind = REQ_AWARD;
        end else begin
            r.kind = REQ_RESTART;
            roll   = $urandom_range(0, 99);
            if (roll < 40) begin
                r.rate = $urandom_range(0, 32'h4_0000);
            end else if (roll < 60) begin
                r.rate = $urandom_range(0, 16);
            end else if (roll < 70) begin
                r.rate = rate_cur;
            end
        end
        return r;
    endfunction

    // Offer one request, wait for its transfer and queue the verdict it must produce.
    task automatic send_item(input t_req_item r, input logic typed, input t_verdict want);
        int       pause;
        t_verdict pred;
        pause = draw_pause(send_calm);
        if (pause > 0) begin
            req_ch.valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= r.kind;
        req_ch.time_now   <= r.stamp;
        req_ch.token_cost <= r.cost;
        req_ch.new_rate   <= r.rate;
        do @(posedge clk); while (!req_ch.ready);
        pred = police_step(r);
        verdict_q.push_back(typed ? want : pred);
        sent_count++;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    endtask

    // Register write, applied to the prediction at the edge where it lands.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_BUCKET_DEPTH: begin
                bkt_depth = data[DEPTH_W-1:0];
                level     = bucket_cap();
            end
            REG_INITIAL_RATE: begin
                rate_cur  = data[RATE_W-1:0];
                rate_prev = '0;
            end
            default: ;
        endcase
        write_count++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering, let every outstanding verdict come back, then allow for latency.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Result side: random back-pressure and comparison against the oldest prediction.
    initial begin : result_sink
        int       pause;
        t_verdict got;
        t_verdict want;
        res_ch.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            pause = draw_pause(recv_calm);
            if (pause > 0) begin
                res_ch.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            got.dropped = res_ch.dropped;
            got.rate    = res_ch.current_rate;
            got.up      = res_ch.up_score;
            got.down    = res_ch.down_score;
            checked_count++;
            if (got.dropped === 1'b1) drop_count++;
            if (verdict_q.size() == 0) begin
                bad_count++;
                if (bad_count <= 10) begin
                    $display("tb_top: unexpected result: drop %0b rate %h up %0d down %0d",
                             got.dropped, got.rate, got.up, got.down);
                end
            end else begin
                want = verdict_q.pop_front();
                if (got.dropped !== want.dropped || got.rate !== want.rate ||
                    got.up !== want.up || got.down !== want.down) begin
                    bad_count++;
                    if (bad_count <= 10) begin
                        $display({"tb_top: result %0d differs: drop %0b/%0b rate %h/%h ",
                                  "up %0d/%0d down %0d/%0d (expected/actual)"},
                                 checked_count, want.dropped, got.dropped, want.rate, got.rate,
                                 want.up, got.up, want.down, got.down);
                    end
                end
            end
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        end
    end

    // Watchdog: too long without a transfer on either channel ends the run.
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int                   p;
        int                   k;
        logic [31:0]          noise;
        logic [DEPTH_W-1:0]   depth_pick;
        logic [RATE_W-1:0]    rate_pick;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_PACKET;
        req_ch.time_now   <= '0;
        req_ch.token_cost <= '0;
        req_ch.new_rate   <= '0;
        cfg_we            <= 1'b0;
        cfg_idx           <= REG_BUCKET_DEPTH;
        cfg_data          <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening with the reset register values.
        for (k = 0; k < SCRIPT_LEN; k++) begin
            send_item(SCRIPT[k].req, SCRIPT[k].typed, SCRIPT[k].want);
        end
        drain();

        // Random phases, each under its own register setting.
        for (p = 0; p < PHASES; p++) begin
            depth_pick = (p < 5) ? DEPTH_PICKS[p] : DEPTH_W'($urandom_range(1, 300));
            rate_pick  = (p < 5) ? RATE_PICKS[p] : RATE_W'($urandom_range(0, 32'h4_0000));
            noise      = $urandom;
            if (p % 2 == 0) begin
                write_reg(REG_BUCKET_DEPTH, {noise[31:16], depth_pick});
                write_reg(REG_INITIAL_RATE, rate_pick);
                // Unmapped indexes must leave every register as it is.
                write_reg(REG_UNMAPPED_A, $urandom);
                write_reg(REG_UNMAPPED_B, $urandom);
            end else begin
                write_reg(REG_INITIAL_RATE, rate_pick);
                write_reg(REG_BUCKET_DEPTH, {noise[31:16], depth_pick});
            end
            repeat (PHASE_ITEMS) send_item(make_item(), 1'b0, '0);
            drain();
        end

        bad_count += verdict_q.size();
        $display("tb_top: %0d requests sent, %0d verdicts checked, %0d of them drops",
                 sent_count, checked_count, drop_count);
        $display("tb_top: %0d register writes across %0d settings, with random stalls",
                 write_count, PHASES + 1);
        if (bad_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
